// ----- rtl/pwsu_pkg.sv -----
`timescale 1ns / 1ps

package pwsu_pkg;

  // field and datapath widths
  localparam int CoefW    = 32;
  localparam int WorldW   = 32;
  localparam int ProdW    = CoefW + WorldW;
  localparam int SumW     = ProdW + 2;
  localparam int FracDrop = 8;
  localparam int ClipW    = 58;
  localparam int NumW     = ClipW + 1;
  localparam int MagW     = ClipW;
  localparam int OutW     = 20;
  localparam int SizeW    = 14;
  localparam int ScreenMax = 8192;
  localparam int ScaleW   = 17;
  localparam int QW       = ScaleW + 1;
  localparam int MulW     = ScaleW + OutW + 1;

  // configuration port
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 64;
  localparam int NumCoefRegs = 6;

  // queue between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = 2;
  localparam int QCntW  = 3;

  // 0.01 rounded up in Q.16
  localparam logic signed [ClipW-1:0] WMin = ClipW'(656);

  typedef enum logic [CfgIdxW-1:0] {
    RegRowX01 = 8'd0,
    RegRowX23 = 8'd1,
    RegRowY01 = 8'd2,
    RegRowY23 = 8'd3,
    RegRowW01 = 8'd4,
    RegRowW23 = 8'd5,
    RegScrW   = 8'd6,
    RegScrH   = 8'd7
  } cfg_reg_e;

  // rows x, y, w; terms c0..c3
  typedef struct packed {
    logic [2:0][3:0][CoefW-1:0] c;
  } coef_t;

  typedef struct packed {
    logic                   vis;
    logic signed [NumW-1:0] nx;
    logic signed [NumW-1:0] ny;
    logic [MagW-1:0]        w;
  } item_t;

  typedef struct packed {
    logic                   vld;
    logic                   vis;
    logic signed [NumW-1:0] num;
    logic [MagW-1:0]        den;
  } lane_in_t;

  typedef struct packed {
    logic                   vld;
    logic                   vis;
    logic signed [OutW-1:0] pix;
  } lane_out_t;

endpackage

// ----- rtl/pwsu_front.sv -----
`timescale 1ns / 1ps

module pwsu_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_vld_i,
  output logic                          s_rdy_o,
  input  logic [3*pwsu_pkg::WorldW-1:0] s_data_i,
  input  pwsu_pkg::coef_t               coef_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output pwsu_pkg::item_t               q_item_o
);

  logic                                 en;
  logic                                 p1_vld_q, p2_vld_q;
  logic signed [pwsu_pkg::ProdW-1:0]    prod_d [3][3];
  logic signed [pwsu_pkg::ProdW-1:0]    prod_q [3][3];
  logic signed [pwsu_pkg::ClipW-1:0]    clip_d [3];
  logic signed [pwsu_pkg::ClipW-1:0]    clip_q [3];

  assign en       = !(p2_vld_q && q_full_i);
  assign s_rdy_o  = en;
  assign q_push_o = p2_vld_q && !q_full_i;

  // nine coefficient by coordinate products
  always_comb begin
    logic signed [pwsu_pkg::CoefW-1:0]  cf;
    logic signed [pwsu_pkg::WorldW-1:0] wv;
    for (int r = 0; r < 3; r++) begin
      for (int t = 0; t < 3; t++) begin
        cf = $signed(coef_i.c[r][t]);
        wv = $signed(s_data_i[t*pwsu_pkg::WorldW +: pwsu_pkg::WorldW]);
        prod_d[r][t] = pwsu_pkg::ProdW'(cf) * pwsu_pkg::ProdW'(wv);
      end
    end
  end

  // row sums, floor to Q.16, add constant term
  always_comb begin
    logic signed [pwsu_pkg::SumW-1:0]  s;
    logic signed [pwsu_pkg::SumW-1:0]  sh;
    logic signed [pwsu_pkg::CoefW-1:0] c3;
    for (int r = 0; r < 3; r++) begin
      s  = pwsu_pkg::SumW'(prod_q[r][0]) + pwsu_pkg::SumW'(prod_q[r][1])
         + pwsu_pkg::SumW'(prod_q[r][2]);
      sh = s >>> pwsu_pkg::FracDrop;
      c3 = $signed(coef_i.c[r][3]);
      clip_d[r] = pwsu_pkg::ClipW'(sh) + pwsu_pkg::ClipW'(c3);
    end
  end

  // classify and form numerators for the back end
  always_comb begin
    q_item_o.vis = clip_q[2] >= pwsu_pkg::WMin;
    q_item_o.nx  = pwsu_pkg::NumW'(clip_q[2]) + pwsu_pkg::NumW'(clip_q[0]);
    q_item_o.ny  = pwsu_pkg::NumW'(clip_q[2]) - pwsu_pkg::NumW'(clip_q[1]);
    q_item_o.w   = pwsu_pkg::MagW'(clip_q[2]);
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
    end else if (en) begin
      p1_vld_q <= s_vld_i;
      p2_vld_q <= p1_vld_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= prod_d;
      clip_q <= clip_d;
    end
  end

endmodule

// ----- rtl/pwsu_queue.sv -----
`timescale 1ns / 1ps

module pwsu_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pwsu_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output pwsu_pkg::item_t item_o
);

  pwsu_pkg::item_t                 mem_q [pwsu_pkg::QDepth];
  logic [pwsu_pkg::QPtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [pwsu_pkg::QCntW-1:0]      cnt_q;

  assign full_o  = cnt_q == pwsu_pkg::QCntW'(pwsu_pkg::QDepth);
  assign empty_o = cnt_q == '0;
  assign item_o  = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= item_i;
  end

endmodule

// ----- rtl/pwsu_div.sv -----
`timescale 1ns / 1ps

module pwsu_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  pwsu_pkg::lane_in_t           in_i,
  input  logic [pwsu_pkg::ScaleW-1:0]  scale_i,
  output pwsu_pkg::lane_out_t          out_o
);

  localparam int NSt = 1 + pwsu_pkg::OutW + pwsu_pkg::ScaleW + 1;

  typedef struct packed {
    logic                          vis;
    logic                          neg;
    logic                          sat;
    logic [pwsu_pkg::MagW-1:0]     rem;
    logic [pwsu_pkg::MagW-1:0]     acc;
    logic [pwsu_pkg::MagW-1:0]     w;
    logic [pwsu_pkg::OutW-1:0]     ip;
    logic [pwsu_pkg::QW-1:0]       q;
    logic [pwsu_pkg::MulW-1:0]     mag;
  } st_t;

  logic vld_q [NSt];
  st_t  st_d  [NSt];
  st_t  st_q  [NSt];

  // prep, integer quotient steps, fraction steps, scale multiply
  always_comb begin
    logic [pwsu_pkg::NumW-1:0]   an;
    logic [pwsu_pkg::MagW-1:0]   mg;
    logic [pwsu_pkg::MagW+1:0]   t;
    logic [pwsu_pkg::MagW+1:0]   w1;
    logic [pwsu_pkg::MagW+1:0]   w2;
    logic [1:0]                  kq;
    logic                        bit_q;
    int                          sh;
    int                          b;
    an = in_i.num[pwsu_pkg::NumW-1] ? pwsu_pkg::NumW'(-in_i.num)
                                      : pwsu_pkg::NumW'(in_i.num);
    mg = pwsu_pkg::MagW'(an);
    st_d[0].vis = in_i.vis;
    st_d[0].neg = in_i.num[pwsu_pkg::NumW-1];
    st_d[0].sat = (mg >> pwsu_pkg::OutW) >= in_i.den;
    st_d[0].rem = mg;
    st_d[0].acc = '0;
    st_d[0].w   = in_i.den;
    st_d[0].ip  = '0;
    st_d[0].q   = '0;
    st_d[0].mag = '0;

    // restoring division, one quotient bit per stage
    for (int k = 1; k <= pwsu_pkg::OutW; k++) begin
      sh       = pwsu_pkg::OutW - k;
      st_d[k]  = st_q[k-1];
      bit_q    = (st_q[k-1].rem >> sh) >= st_q[k-1].w;
      if (bit_q) st_d[k].rem = st_q[k-1].rem - (st_q[k-1].w << sh);
      st_d[k].ip = {st_q[k-1].ip[pwsu_pkg::OutW-2:0], bit_q};
    end

    // scale times remainder over divisor, one scale bit per stage
    for (int k = pwsu_pkg::OutW + 1; k <= pwsu_pkg::OutW + pwsu_pkg::ScaleW; k++) begin
      b       = pwsu_pkg::ScaleW - 1 - (k - pwsu_pkg::OutW - 1);
      st_d[k] = st_q[k-1];
      t  = (pwsu_pkg::MagW+2)'(st_q[k-1].acc) << 1;
      if (scale_i[b]) t = t + (pwsu_pkg::MagW+2)'(st_q[k-1].rem);
      w1 = (pwsu_pkg::MagW+2)'(st_q[k-1].w);
      w2 = w1 << 1;
      kq = 2'd0;
      if (t >= w2) begin
        t  = t - w2;
        kq = 2'd2;
      end else if (t >= w1) begin
        t  = t - w1;
        kq = 2'd1;
      end
      st_d[k].acc = pwsu_pkg::MagW'(t);
      st_d[k].q   = (st_q[k-1].q << 1) + pwsu_pkg::QW'(kq);
    end

    // whole part times scale plus fraction part
    st_d[NSt-1]     = st_q[NSt-2];
    st_d[NSt-1].mag = pwsu_pkg::MulW'(scale_i) * pwsu_pkg::MulW'(st_q[NSt-2].ip)
                    + pwsu_pkg::MulW'(st_q[NSt-2].q);
  end

  // saturate to the output range; zero when not visible or when the scale is zero
  always_comb begin
    logic [pwsu_pkg::MulW-1:0] lim;
    logic [pwsu_pkg::MulW-1:0] mc;
    lim = st_q[NSt-1].neg ? (pwsu_pkg::MulW'(1) << (pwsu_pkg::OutW - 1))
                          : ((pwsu_pkg::MulW'(1) << (pwsu_pkg::OutW - 1)) - 1'b1);
    mc  = (st_q[NSt-1].sat || st_q[NSt-1].mag > lim) ? lim : st_q[NSt-1].mag;
    out_o.vld = vld_q[NSt-1];
    out_o.vis = st_q[NSt-1].vis;
    if (!st_q[NSt-1].vis || scale_i == '0) out_o.pix = '0;
    else if (st_q[NSt-1].neg)              out_o.pix = pwsu_pkg::OutW'(-mc);
    else                                   out_o.pix = pwsu_pkg::OutW'(mc);
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NSt; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= in_i.vld;
      for (int k = 1; k < NSt; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NSt; k++) st_q[k] <= st_d[k];
    end
  end

endmodule

// ----- rtl/perspective_world_to_screen_unit.sv -----
`timescale 1ns / 1ps

// channel   | direction | beat contents
// s_axis    | in        | tdata: world_x, world_y, world_z
// m_axis    | out       | tdata: pixel_x, pixel_y; tuser: visible
// cfg       | in        | cfg_index_i register, cfg_data_i value
//
// one point per cycle in and out when neither side stalls
// pipeline is 2 product/sum stages, queue, 39 divider stages, output register
// the divider pipeline (one quotient bit per stage) sets the latency
// reset clears valids and loads the default screen size; coefficients reset to zero
// an output stall holds the back end; the front fills the queue and then stalls input

module perspective_world_to_screen_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [95:0]                      s_axis_tdata,  // world_x, world_y, world_z
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [39:0]                      m_axis_tdata,  // pixel_x, pixel_y
  output logic [0:0]                       m_axis_tuser,  // visible
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pwsu_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [pwsu_pkg::CfgDataW-1:0]    cfg_data_i
);

  logic [pwsu_pkg::CfgDataW-1:0]  coef_reg_q [pwsu_pkg::NumCoefRegs];
  logic [pwsu_pkg::SizeW-1:0]     scr_w_q, scr_h_q;
  pwsu_pkg::coef_t                coef;
  logic [pwsu_pkg::SizeW-1:0]     sw_sat, sh_sat;
  logic [pwsu_pkg::ScaleW-1:0]    scale_x, scale_y;

  logic                           q_push, q_full, q_pop, q_empty;
  pwsu_pkg::item_t                q_in, q_out;
  logic                           back_en;
  pwsu_pkg::lane_in_t             lx_in, ly_in;
  pwsu_pkg::lane_out_t            lx_out, ly_out;

  logic                           out_vld_q;
  logic                           out_vis_q;
  logic [pwsu_pkg::OutW-1:0]      out_px_q, out_py_q;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pwsu_pkg::NumCoefRegs; i++) coef_reg_q[i] <= '0;
      scr_w_q <= pwsu_pkg::SizeW'(1920);
      scr_h_q <= pwsu_pkg::SizeW'(1080);
    end else if (cfg_valid_i) begin
      unique case (pwsu_pkg::cfg_reg_e'(cfg_index_i))
        pwsu_pkg::RegRowX01: coef_reg_q[0] <= cfg_data_i;
        pwsu_pkg::RegRowX23: coef_reg_q[1] <= cfg_data_i;
        pwsu_pkg::RegRowY01: coef_reg_q[2] <= cfg_data_i;
        pwsu_pkg::RegRowY23: coef_reg_q[3] <= cfg_data_i;
        pwsu_pkg::RegRowW01: coef_reg_q[4] <= cfg_data_i;
        pwsu_pkg::RegRowW23: coef_reg_q[5] <= cfg_data_i;
        pwsu_pkg::RegScrW:   scr_w_q <= cfg_data_i[pwsu_pkg::SizeW-1:0];
        pwsu_pkg::RegScrH:   scr_h_q <= cfg_data_i[pwsu_pkg::SizeW-1:0];
        default: ;
      endcase
    end
  end

  // unpack coefficient halves
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      coef.c[r][0] = coef_reg_q[2*r][pwsu_pkg::CoefW-1:0];
      coef.c[r][1] = coef_reg_q[2*r][32 +: pwsu_pkg::CoefW];
      coef.c[r][2] = coef_reg_q[2*r+1][pwsu_pkg::CoefW-1:0];
      coef.c[r][3] = coef_reg_q[2*r+1][32 +: pwsu_pkg::CoefW];
    end
  end

  // screen size clamp, scale is 8x size
  assign sw_sat  = (scr_w_q > pwsu_pkg::SizeW'(pwsu_pkg::ScreenMax))
                 ? pwsu_pkg::SizeW'(pwsu_pkg::ScreenMax) : scr_w_q;
  assign sh_sat  = (scr_h_q > pwsu_pkg::SizeW'(pwsu_pkg::ScreenMax))
                 ? pwsu_pkg::SizeW'(pwsu_pkg::ScreenMax) : scr_h_q;
  assign scale_x = pwsu_pkg::ScaleW'(sw_sat) << 3;
  assign scale_y = pwsu_pkg::ScaleW'(sh_sat) << 3;

  pwsu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_vld_i  (s_axis_tvalid),
    .s_rdy_o  (s_axis_tready),
    .s_data_i (s_axis_tdata),
    .coef_i   (coef),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_item_o (q_in)
  );

  pwsu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (q_out)
  );

  // back end advances whenever the output register can take a beat
  assign back_en = !out_vld_q || m_axis_tready;
  assign q_pop   = back_en && !q_empty;

  always_comb begin
    lx_in.vld = !q_empty;
    lx_in.vis = q_out.vis;
    lx_in.num = q_out.nx;
    lx_in.den = q_out.w;
    ly_in.vld = !q_empty;
    ly_in.vis = q_out.vis;
    ly_in.num = q_out.ny;
    ly_in.den = q_out.w;
  end

  pwsu_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (back_en),
    .in_i    (lx_in),
    .scale_i (scale_x),
    .out_o   (lx_out)
  );

  pwsu_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (back_en),
    .in_i    (ly_in),
    .scale_i (scale_y),
    .out_o   (ly_out)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (back_en) begin
      out_vld_q <= lx_out.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (back_en) begin
      out_vis_q <= lx_out.vis;
      out_px_q  <= lx_out.pix;
      out_py_q  <= ly_out.pix;
    end
  end

  assign m_axis_tvalid   = out_vld_q;
  assign m_axis_tdata    = {out_py_q, out_px_q};
  assign m_axis_tuser[0] = out_vis_q;

`ifndef NO_ASSERTIONS
  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tdata == '0)
    else $error("point behind the eye with nonzero coordinates");

  a_lanes_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lx_out.vld == ly_out.vld)
    else $error("x and y divider lanes out of step");

  a_out_from_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(lx_out.vld))
    else $error("output beat without a divider result");
`endif

endmodule

// ----- dv/perspective_world_to_screen_unit_tb.sv -----
`timescale 1ns / 1ps

module perspective_world_to_screen_unit_tb;

  // one projected point as it leaves the block
  typedef struct packed {
    logic                             visible;
    logic signed [pwsu_pkg::OutW-1:0] pixel_x;
    logic signed [pwsu_pkg::OutW-1:0] pixel_y;
  } screen_point_t;

  // projection predictor plus the queue of pending screen points
  class projection_scoreboard;
    logic [pwsu_pkg::CfgDataW-1:0] coef_reg[pwsu_pkg::NumCoefRegs];
    logic [pwsu_pkg::SizeW-1:0]    scr_w, scr_h;
    screen_point_t                 pending[$];
    int                            errors;

    function new();
      foreach (coef_reg[i]) coef_reg[i] = '0;
      scr_w  = pwsu_pkg::SizeW'(1920);
      scr_h  = pwsu_pkg::SizeW'(1080);
      errors = 0;
    endfunction

    function void write_reg(logic [pwsu_pkg::CfgIdxW-1:0] idx,
                            logic [pwsu_pkg::CfgDataW-1:0] val);
      if (idx == pwsu_pkg::RegScrW) scr_w = val[pwsu_pkg::SizeW-1:0];
      else if (idx == pwsu_pkg::RegScrH) scr_h = val[pwsu_pkg::SizeW-1:0];
      else if (idx < pwsu_pkg::NumCoefRegs) coef_reg[idx] = val;
    endfunction

    // one matrix row dotted with the point, Q.16, floor of the exact sum
    function logic signed [69:0] clip_of(int row, logic signed [31:0] x,
                                         logic signed [31:0] y, logic signed [31:0] z);
      logic signed [31:0] c0, c1, c2, c3;
      logic signed [69:0] acc;
      c0  = coef_reg[2*row][31:0];
      c1  = coef_reg[2*row][63:32];
      c2  = coef_reg[2*row+1][31:0];
      c3  = coef_reg[2*row+1][63:32];
      acc = longint'(c0) * longint'(x);
      acc = acc + longint'(c1) * longint'(y);
      acc = acc + longint'(c2) * longint'(z);
      acc = acc >>> 8;
      return acc + c3;
    endfunction

    // trunc(m * n / w) saturated to the output range
    function logic [pwsu_pkg::OutW-1:0] to_pixel(logic [17:0] m, logic signed [69:0] n,
                                                 logic signed [69:0] w);
      logic signed [127:0] num, den, mm, quo;
      if (m == 0) return '0;
      mm  = m;
      num = n;
      den = w;
      quo = (num * mm) / den;
      if (quo > 524287) quo = 524287;
      if (quo < -524288) quo = -524288;
      return quo[pwsu_pkg::OutW-1:0];
    endfunction

    function void note_point(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z);
      logic signed [69:0] cx, cy, cw;
      logic [17:0]        mw, mh;
      screen_point_t      sp;
      cx = clip_of(0, x, y, z);
      cy = clip_of(1, x, y, z);
      cw = clip_of(2, x, y, z);
      mw = 18'(8 * ((scr_w > pwsu_pkg::ScreenMax) ? pwsu_pkg::ScreenMax : int'(scr_w)));
      mh = 18'(8 * ((scr_h > pwsu_pkg::ScreenMax) ? pwsu_pkg::ScreenMax : int'(scr_h)));
      sp = '0;
      if (cw >= 656) begin
        sp.visible = 1'b1;
        sp.pixel_x = to_pixel(mw, cw + cx, cw);
        sp.pixel_y = to_pixel(mh, cw - cy, cw);
      end
      pending.push_back(sp);
    endfunction

    function void check(screen_point_t got);
      screen_point_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat vis=%0b x=%0d y=%0d", $time, got.visible,
                 got.pixel_x, got.pixel_y);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.visible !== want.visible) begin
        $display("%0t: visible exp %0b got %0b", $time, want.visible, got.visible);
        errors++;
      end
      if (got.pixel_x !== want.pixel_x) begin
        $display("%0t: pixel_x exp %0d got %0d", $time, want.pixel_x, got.pixel_x);
        errors++;
      end
      if (got.pixel_y !== want.pixel_y) begin
        $display("%0t: pixel_y exp %0d got %0d", $time, want.pixel_y, got.pixel_y);
        errors++;
      end
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [95:0]                   s_axis_tdata = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [39:0]                   m_axis_tdata;
  logic [0:0]                    m_axis_tuser;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [pwsu_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [pwsu_pkg::CfgDataW-1:0] cfg_data_i = '0;

  projection_scoreboard proj_sb = new();
  int src_idle_pct = 0;
  int snk_stall_pct = 0;

  perspective_world_to_screen_unit dut (.*);

  always #6 clk_i = ~clk_i;

  // receiver stalls
  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);

  // input and output monitors
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      proj_sb.note_point(s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tdata[95:64]);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      proj_sb.check({m_axis_tuser[0], m_axis_tdata[19:0], m_axis_tdata[39:20]});
  end

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {z, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (proj_sb.pending.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [pwsu_pkg::CfgIdxW-1:0] idx,
                           logic [pwsu_pkg::CfgDataW-1:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    proj_sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [31:0] q16(int v);
    return 32'(v) << 16;
  endfunction

  // coefficient mix: full range, moderate, extremes
  function automatic logic [31:0] rand_coef();
    case ($urandom_range(9))
      0, 1: return $urandom;
      2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return 32'($signed($urandom_range(262144)) - 131072);
    endcase
  endfunction

  function automatic logic [31:0] rand_world();
    case ($urandom_range(7))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2097152)) - 1048576);
      default: return 32'($signed($urandom_range(16384)) - 8192);
    endcase
  endfunction

  function automatic logic [13:0] rand_size();
    case ($urandom_range(5))
      0: return 14'd0;
      1: return 14'd1;
      2: return 14'd8192;
      3: return 14'h3fff;
      default: return 14'($urandom_range(1, 8192));
    endcase
  endfunction

  initial begin
    logic [31:0] c3;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset matrix is all zero: nothing visible
    send_point(32'd100, 32'd200, 32'd300);
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    wait_drained();

    // identity-like matrix, w taken from z
    write_cfg(pwsu_pkg::RegRowX01, {32'd0, q16(1)});
    write_cfg(pwsu_pkg::RegRowX23, 64'd0);
    write_cfg(pwsu_pkg::RegRowY01, {q16(1), 32'd0});
    write_cfg(pwsu_pkg::RegRowY23, 64'd0);
    write_cfg(pwsu_pkg::RegRowW01, 64'd0);
    write_cfg(pwsu_pkg::RegRowW23, {32'd0, q16(1)});
    write_cfg(8'd8, 64'($urandom));
    write_cfg(8'hff, 64'($urandom));
    send_point(32'd0, 32'd0, 32'd3);       // just above the visibility threshold
    send_point(32'd0, 32'd0, 32'd2);       // just below it
    send_point(32'd0, 32'd0, 32'd0);
    send_point(32'd5, 32'd5, 32'hffff_fff0);
    send_point(32'd256, 32'hffff_ff00, 32'd256);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'd3);   // saturation high/low
    send_point(32'h8000_0000, 32'h8000_0000, 32'd3);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_point(32'hffff_ffff, 32'd1, 32'd1000);
    wait_drained();

    // screen size of zero and above the maximum
    write_cfg(pwsu_pkg::RegScrW, 64'd0);
    write_cfg(pwsu_pkg::RegScrH, 64'h3fff);
    send_point(32'd100, 32'd100, 32'd512);
    send_point(32'hffff_ff00, 32'd700, 32'd300);
    wait_drained();
    write_cfg(pwsu_pkg::RegScrW, 64'd8192);
    write_cfg(pwsu_pkg::RegScrH, 64'd1);
    send_point(32'd100, 32'd100, 32'd512);
    send_point(32'hffff_ff00, 32'd700, 32'd300);
    wait_drained();

    // extreme coefficients everywhere
    for (int r = 0; r < pwsu_pkg::NumCoefRegs; r++)
      write_cfg(pwsu_pkg::CfgIdxW'(r), {32'h8000_0000, 32'h7fff_ffff});
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    wait_drained();

    // random phases, idling pattern cycles through four settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 63; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 63; end
        default: begin src_idle_pct = 24; snk_stall_pct = 24; end
      endcase
      // w translation mostly positive so many points stay visible
      c3 = ($urandom_range(3) == 0) ? rand_coef() : 32'($urandom_range(4096, 1 << 24));
      write_cfg(pwsu_pkg::RegScrH, 64'(rand_size()));
      write_cfg(pwsu_pkg::RegRowX01, {rand_coef(), rand_coef()});
      write_cfg(pwsu_pkg::RegRowX23, {rand_coef(), rand_coef()});
      write_cfg(pwsu_pkg::RegRowY01, {rand_coef(), rand_coef()});
      write_cfg(pwsu_pkg::RegRowY23, {rand_coef(), rand_coef()});
      write_cfg(pwsu_pkg::RegRowW01, {rand_coef(), rand_coef()});
      write_cfg(pwsu_pkg::RegRowW23, {c3, rand_coef()});
      write_cfg(pwsu_pkg::RegScrW, 64'(rand_size()));
      for (int n = 0; n < 220; n++) begin
        send_point(rand_world(), rand_world(), rand_world());
      end
      wait_drained();
    end

    if (proj_sb.errors == 0 && proj_sb.pending.size() == 0) begin
      $display("perspective_world_to_screen_unit_tb OK");
    end else begin
      $display("perspective_world_to_screen_unit_tb NOT OK");
    end
    $finish;
  end

  // run limit
  initial begin
    #50_000_000;
    $display("perspective_world_to_screen_unit_tb NOT OK");
    $finish;
  end

endmodule

// ----- perspective_world_to_screen_unit.f -----
rtl/pwsu_pkg.sv
rtl/pwsu_front.sv
rtl/pwsu_queue.sv
rtl/pwsu_div.sv
rtl/perspective_world_to_screen_unit.sv
dv/perspective_world_to_screen_unit_tb.sv
